// ===== rtl/core/upd_pkg.sv =====
// Shared types and codes of the UART packet deframer.
`default_nettype none

package upd_pkg;

    // Result event codes
    localparam logic [2:0] EV_DATA     = 3'd0;
    localparam logic [2:0] EV_OK       = 3'd1;
    localparam logic [2:0] EV_CSUM_ERR = 3'd2;
    localparam logic [2:0] EV_STOP_ERR = 3'd3;
    localparam logic [2:0] EV_TIMEOUT  = 3'd4;

    // Input item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_START_BYTE    = 2'd0;
    localparam logic [1:0] REG_STOP_BYTE     = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

    // Register reset values
    localparam logic [7:0]  START_BYTE_RST    = 8'hD0;
    localparam logic [7:0]  STOP_BYTE_RST     = 8'h0A;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic [7:0] msg_id;
        logic [7:0] msg_size;
        logic [7:0] sum_value;
    } result_t;

    typedef struct packed {
        logic [1:0]  reg_index;
        logic [15:0] reg_data;
    } cfg_t;

    // Queue head as seen by the output stage
    typedef struct packed {
        logic    valid;
        result_t data;
    } queue_head_t;

endpackage

`default_nettype wire

// ===== rtl/core/upd_chan_if.sv =====
// Valid/ready channel carrying one payload beat.
`default_nettype none

interface upd_chan_if #(
    parameter type payload_t = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/upd_front.sv =====
// Front part: takes bytes and ticks, tracks the packet phase, emits result records.
`default_nettype none

module upd_front
    import upd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    upd_chan_if.sink     items,
    upd_chan_if.sink     cfg,
    input  wire logic    queue_full,
    output logic         push,
    output result_t      push_data
);

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_ID   = 3'd1,
        PH_SIZE = 3'd2,
        PH_DATA = 3'd3,
        PH_CSUM = 3'd4,
        PH_STOP = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  start_reg;
    logic [7:0]  stop_reg;
    logic [15:0] timeout_reg;
    logic [7:0]  cur_id_reg, cur_id_next;
    logic [7:0]  cur_size_reg, cur_size_next;
    logic [7:0]  bytes_seen_reg, bytes_seen_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] idle_reg, idle_next;
    logic        item_fire;
    logic        cfg_fire;
    item_t       item;

    // Accept a beat whenever the queue has room; registers take writes at once
    assign items.ready = !queue_full;
    assign cfg.ready   = 1'b1;
    assign item_fire   = items.valid && items.ready;
    assign cfg_fire    = cfg.valid && cfg.ready;
    assign item        = items.payload;

    // Next packet state and result record for the beat
    always_comb
    begin
        phase_next      = phase_reg;
        cur_id_next     = cur_id_reg;
        cur_size_next   = cur_size_reg;
        bytes_seen_next = bytes_seen_reg;
        sum_next        = sum_reg;
        idle_next       = idle_reg;
        push            = 1'b0;
        push_data.event_res    = EV_DATA;
        push_data.payload_byte = 8'd0;
        push_data.byte_index   = 8'd0;
        push_data.msg_id       = cur_id_reg;
        push_data.msg_size     = cur_size_reg;
        push_data.sum_value    = sum_reg;
        if (item_fire)
        begin
            if (item.kind == KIND_TICK)
            begin
                if (phase_reg != PH_HUNT)
                begin
                    if (idle_reg >= timeout_reg)
                    begin
                        phase_next = PH_HUNT;
                        idle_next  = 16'd0;
                        push       = 1'b1;
                        push_data.event_res = EV_TIMEOUT;
                    end
                    else
                    begin
                        idle_next = idle_reg + 16'd1;
                    end
                end
            end
            else
            begin
                idle_next = 16'd0;
                case (phase_reg)
                    PH_ID:
                    begin
                        cur_id_next = item.rx_byte;
                        phase_next  = PH_SIZE;
                    end
                    PH_SIZE:
                    begin
                        cur_size_next   = item.rx_byte;
                        bytes_seen_next = 8'd0;
                        phase_next      = (item.rx_byte != 8'd0) ? PH_DATA : PH_CSUM;
                    end
                    PH_DATA:
                    begin
                        sum_next        = sum_reg + item.rx_byte;
                        bytes_seen_next = bytes_seen_reg + 8'd1;
                        if (bytes_seen_next == cur_size_reg)
                        begin
                            phase_next = PH_CSUM;
                        end
                        push                   = 1'b1;
                        push_data.event_res    = EV_DATA;
                        push_data.payload_byte = item.rx_byte;
                        push_data.byte_index   = bytes_seen_reg;
                        push_data.sum_value    = sum_next;
                    end
                    PH_CSUM:
                    begin
                        if (item.rx_byte == sum_reg)
                        begin
                            phase_next = PH_STOP;
                        end
                        else
                        begin
                            phase_next          = PH_HUNT;
                            push                = 1'b1;
                            push_data.event_res = EV_CSUM_ERR;
                        end
                    end
                    PH_STOP:
                    begin
                        phase_next          = PH_HUNT;
                        push                = 1'b1;
                        push_data.event_res = (item.rx_byte == stop_reg) ? EV_OK
                                                                         : EV_STOP_ERR;
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                        if (item.rx_byte == start_reg)
                        begin
                            phase_next      = PH_ID;
                            cur_id_next     = 8'd0;
                            cur_size_next   = 8'd0;
                            bytes_seen_next = 8'd0;
                            sum_next        = 8'd0;
                        end
                    end
                endcase
            end
        end
    end

    // Hold phase, packet fields and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            cur_id_reg     <= 8'd0;
            cur_size_reg   <= 8'd0;
            bytes_seen_reg <= 8'd0;
            sum_reg        <= 8'd0;
            idle_reg       <= 16'd0;
            start_reg      <= START_BYTE_RST;
            stop_reg       <= STOP_BYTE_RST;
            timeout_reg    <= TIMEOUT_TICKS_RST;
        end
        else
        begin
            phase_reg      <= phase_next;
            cur_id_reg     <= cur_id_next;
            cur_size_reg   <= cur_size_next;
            bytes_seen_reg <= bytes_seen_next;
            sum_reg        <= sum_next;
            idle_reg       <= idle_next;
            if (cfg_fire)
            begin
                case (cfg.payload.reg_index)
                    REG_START_BYTE:    start_reg   <= cfg.payload.reg_data[7:0];
                    REG_STOP_BYTE:     stop_reg    <= cfg.payload.reg_data[7:0];
                    REG_TIMEOUT_TICKS: timeout_reg <= cfg.payload.reg_data;
                    default:           ;
                endcase
            end
        end
    end

    // A record is only produced by an accepted beat
    a_push_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> item_fire)
        else $error("result record without an accepted beat");

    // A payload byte advances the byte position by one
    a_data_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && item.kind == KIND_BYTE && phase_reg == PH_DATA)
        |=> bytes_seen_reg == $past(bytes_seen_reg) + 8'd1)
        else $error("byte position did not advance on a payload byte");

    // Any byte clears the idle tick count
    a_byte_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && item.kind == KIND_BYTE) |=> idle_reg == 16'd0)
        else $error("idle count not cleared by a byte");

    // The idle count stays zero while hunting
    a_hunt_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HUNT |-> idle_reg == 16'd0)
        else $error("idle count nonzero while hunting");

endmodule

`default_nettype wire

// ===== rtl/core/upd_queue.sv =====
// Short result queue between the front part and the output stage.
`default_nettype none

module upd_queue
    import upd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  result_t       push_data,
    input  wire logic     pop,
    output logic          full,
    output queue_head_t   head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.data  = mem_reg[head_reg];
    assign do_pop     = pop && head.valid;

    // Advance pointers and count
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Hold pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Store pushed records
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[tail_reg] <= push_data;
        end
    end

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full result queue");

    // The count never exceeds the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue count out of range");

    // Pointers agree with the count
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

// ===== rtl/core/upd_back.sv =====
// Back part: output register that presents result beats to the sink.
`default_nettype none

module upd_back
    import upd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  queue_head_t   head,
    output logic          pop,
    upd_chan_if.source    results
);

    logic    out_valid_reg;
    result_t out_data_reg;

    // Load the output register when it is empty or being taken
    assign pop             = head.valid && (!out_valid_reg || results.ready);
    assign results.valid   = out_valid_reg;
    assign results.payload = out_data_reg;

    // Hold the output beat until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || results.ready)
        begin
            out_valid_reg <= head.valid;
        end
    end

    // Capture the queue head on a pop
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= head.data;
        end
    end

    // A stalled beat keeps its contents
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !results.ready) |=> out_valid_reg && $stable(out_data_reg))
        else $error("stalled output beat changed");

    // Event code on the output stays within the defined events
    a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.event_res <= EV_TIMEOUT)
        else $error("undefined event code on output");

    // Only payload events carry a payload byte
    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.event_res != EV_DATA)
        |-> (out_data_reg.payload_byte == 8'd0 && out_data_reg.byte_index == 8'd0))
        else $error("non-payload event with payload fields set");

endmodule

`default_nettype wire

// ===== rtl/core/uart_packet_deframer.sv =====
// Top level of the UART packet deframer.
// Each input beat is a received byte or one idle tick. The deframer hunts for the
// start byte, then takes a message id, a size byte, that many payload bytes (each
// passed on as a result beat with its position and the running 8-bit sum), a
// checksum byte and a stop byte, and ends the packet with OK, checksum error or
// stop error; more than timeout_ticks idle ticks inside a packet drop it with a
// timeout event. One input beat is taken every cycle while the queue has room.
// Results are registered in a QUEUE_DEPTH-entry queue and then in an output
// register, and input stalls only when the queue is full while the result sink
// holds off.
// Registers are written through the cfg channel, which is always ready.
`default_nettype none

module uart_packet_deframer
    import upd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    upd_chan_if.sink    items,
    upd_chan_if.sink    cfg,
    upd_chan_if.source  results
);

    logic        push;
    result_t     push_data;
    logic        pop;
    logic        queue_full;
    queue_head_t head;

    upd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (queue_full),
        .head      (head)
    );

    upd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .results (results)
    );

endmodule

`default_nettype wire
